// ===== rtl/rrt_pkg.sv =====
// Shared types and constants of the region residency table.
package rrt_pkg;

    localparam int COORD_BITS = 16;
    // Widest remainder that any legal region size leaves.
    localparam int REM_BITS   = 6;
    localparam int MUL_BITS   = COORD_BITS + 2;
    localparam int PROD_BITS  = COORD_BITS + MUL_BITS;

    typedef struct packed {
        logic                          action;
        logic signed [COORD_BITS-1:0]  longitude;
        logic signed [COORD_BITS-1:0]  latitude;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  region_lon;
        logic signed [COORD_BITS-1:0]  region_lat;
        logic [7:0]                    chunk_index;
        logic [3:0]                    slot;
        logic                          load_request;
        logic                          save_request;
        logic                          flag_changed;
        logic                          table_full;
    } t_result;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic                   release_op;
        logic [COORD_BITS-1:0]  olon;
        logic [COORD_BITS-1:0]  olat;
        logic [REM_BITS-1:0]    rx;
        logic [REM_BITS-1:0]    ry;
    } t_cls;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MATCH,
        ST_READ,
        ST_UPDATE
    } t_state;

endpackage

// ===== rtl/region_residency_table_top.sv =====
// Region residency table: top level with front, queue, back and checks.
//
// Input channel: an item (acquire or release of one chunk at signed
// coordinates) is taken on a rising edge with push high and full low.
// Result channel: while empty is low the oldest result sits on o_result and
// is taken on a rising edge with pop high. Each item gives exactly one result.
// The front pipeline works out region origin and chunk offsets in two stages
// and hands them through a two-entry queue to the back end. The back end
// handles one item at a time: queue pop, slot match, slot select and flag
// read, then flag and count update. It takes no new item from the queue
// until the result of the item at hand is written to the result register.
// A stalled receiver holds the result register; the back end then waits with
// its next result and the queue and front pipeline fill, after which full rises.
// After reset the chunk flag memory is cleared one entry per cycle, over
// MAX_REGIONS * REGION_WIDTH * REGION_HEIGHT entries (4096 by default);
// full stays high during that pass. Reset empties all slots.
module region_residency_table_top #(
    parameter int REGION_WIDTH  = 16,
    parameter int REGION_HEIGHT = 16,
    parameter int MAX_REGIONS   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rrt_pkg::t_in_item i_item,
    output logic              empty,
    input  logic              pop,
    output rrt_pkg::t_result  o_result
);
    import rrt_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    logic clearing;
    t_cls front_cls;
    t_cls queue_cls;

    rrt_front #(
        .REGION_WIDTH  (REGION_WIDTH),
        .REGION_HEIGHT (REGION_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_hold   (clearing),
        .o_full   (full),
        .i_item   (i_item),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_cls    (front_cls)
    );

    rrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_data  (front_cls),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (queue_cls)
    );

    rrt_back #(
        .REGION_WIDTH  (REGION_WIDTH),
        .REGION_HEIGHT (REGION_HEIGHT),
        .MAX_REGIONS   (MAX_REGIONS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cls      (queue_cls),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_result   (o_result),
        .o_empty    (empty),
        .i_pop      (pop)
    );

    // The flag clearing pass must keep the input closed right after reset.
    a_closed_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("input open right after reset");

    // A full table changes nothing and reports no slot.
    a_full_is_inert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.table_full) |->
        (o_result.slot == 4'd0 && !o_result.load_request &&
         !o_result.save_request && !o_result.flag_changed))
        else $error("table full result carries side effects");

    // An acquire that loads a region always finds the chunk flag clear.
    a_new_region_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.load_request && !o_result.save_request) |->
        o_result.flag_changed)
        else $error("newly loaded region held a set chunk flag");

    // Load and release of an unknown region never reports a flag change.
    a_absent_release_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.load_request && o_result.save_request) |->
        !o_result.flag_changed)
        else $error("release in absent region changed a flag");

endmodule

// ===== rtl/rrt_front.sv =====
// Front pipeline: splits chunk coordinates into region origin and chunk offsets.
module rrt_front #(
    parameter int REGION_WIDTH  = 16,
    parameter int REGION_HEIGHT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_hold,
    output logic              o_full,
    input  rrt_pkg::t_in_item i_item,
    output logic              o_q_push,
    input  logic              i_q_full,
    output rrt_pkg::t_cls     o_cls
);
    import rrt_pkg::*;

    // Unsigned division by reciprocal: q = (u * M) >> S is exact for 16-bit u.
    localparam int LON_SH = COORD_BITS + $clog2(REGION_WIDTH);
    localparam int LAT_SH = COORD_BITS + $clog2(REGION_HEIGHT);
    localparam logic [MUL_BITS-1:0] LON_MUL = MUL_BITS'(
        ((64'd1 << LON_SH) + 64'(REGION_WIDTH) - 64'd1) / 64'(REGION_WIDTH));
    localparam logic [MUL_BITS-1:0] LAT_MUL = MUL_BITS'(
        ((64'd1 << LAT_SH) + 64'(REGION_HEIGHT) - 64'd1) / 64'(REGION_HEIGHT));
    // The coordinate is biased by half the range; this undoes the bias in the remainder.
    localparam int LON_OFS = (1 << (COORD_BITS - 1)) % REGION_WIDTH;
    localparam int LAT_OFS = (1 << (COORD_BITS - 1)) % REGION_HEIGHT;
    localparam logic [COORD_BITS-1:0] BIAS = COORD_BITS'(1 << (COORD_BITS - 1));

    logic                   r_a_valid;
    logic                   r_a_release;
    logic [COORD_BITS-1:0]  r_a_ulon;
    logic [COORD_BITS-1:0]  r_a_ulat;
    logic [PROD_BITS-1:0]   r_a_plon;
    logic [PROD_BITS-1:0]   r_a_plat;
    logic                   r_b_valid;
    t_cls                   r_b_cls;

    logic                   en;
    logic                   accept;
    logic [COORD_BITS-1:0]  n_ulon;
    logic [COORD_BITS-1:0]  n_ulat;
    logic [COORD_BITS-1:0]  q_lon;
    logic [COORD_BITS-1:0]  q_lat;
    logic [COORD_BITS-1:0]  m_lon;
    logic [COORD_BITS-1:0]  m_lat;
    logic [REM_BITS:0]      ru_lon;
    logic [REM_BITS:0]      ru_lat;
    logic [REM_BITS:0]      r_lon;
    logic [REM_BITS:0]      r_lat;
    t_cls                   n_b_cls;

    assign en       = !(r_b_valid && i_q_full);
    assign o_full   = !en || i_hold;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_b_valid && !i_q_full;
    assign o_cls    = r_b_cls;

    assign n_ulon = i_item.longitude ^ BIAS;
    assign n_ulat = i_item.latitude ^ BIAS;

    always_comb begin
        q_lon  = COORD_BITS'(r_a_plon >> LON_SH);
        q_lat  = COORD_BITS'(r_a_plat >> LAT_SH);
        m_lon  = r_a_ulon - COORD_BITS'(q_lon * COORD_BITS'(REGION_WIDTH));
        m_lat  = r_a_ulat - COORD_BITS'(q_lat * COORD_BITS'(REGION_HEIGHT));
        ru_lon = m_lon[REM_BITS:0];
        ru_lat = m_lat[REM_BITS:0];
        if (ru_lon >= (REM_BITS+1)'(LON_OFS)) begin
            r_lon = ru_lon - (REM_BITS+1)'(LON_OFS);
        end else begin
            r_lon = ru_lon + (REM_BITS+1)'(REGION_WIDTH - LON_OFS);
        end
        if (ru_lat >= (REM_BITS+1)'(LAT_OFS)) begin
            r_lat = ru_lat - (REM_BITS+1)'(LAT_OFS);
        end else begin
            r_lat = ru_lat + (REM_BITS+1)'(REGION_HEIGHT - LAT_OFS);
        end
        n_b_cls.release_op = r_a_release;
        n_b_cls.olon       = (r_a_ulon ^ BIAS) - COORD_BITS'(r_lon);
        n_b_cls.olat       = (r_a_ulat ^ BIAS) - COORD_BITS'(r_lat);
        n_b_cls.rx         = r_lon[REM_BITS-1:0];
        n_b_cls.ry         = r_lat[REM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_release <= i_item.action;
            r_a_ulon    <= n_ulon;
            r_a_ulat    <= n_ulat;
            r_a_plon    <= PROD_BITS'(n_ulon) * PROD_BITS'(LON_MUL);
            r_a_plat    <= PROD_BITS'(n_ulat) * PROD_BITS'(LAT_MUL);
            r_b_cls     <= n_b_cls;
        end
    end

endmodule

// ===== rtl/rrt_queue.sv =====
// Two-entry queue between the front and the back.
module rrt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  rrt_pkg::t_cls i_data,
    input  logic          i_pop,
    output logic          o_empty,
    output rrt_pkg::t_cls o_data
);
    import rrt_pkg::*;

    localparam int DEPTH = 2;

    t_cls        r_data [DEPTH];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        do_push;
    logic        do_pop;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_data[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/rrt_back.sv =====
// Back end: slot lookup, chunk flag read-modify-write and result register.
module rrt_back #(
    parameter int REGION_WIDTH  = 16,
    parameter int REGION_HEIGHT = 16,
    parameter int MAX_REGIONS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  rrt_pkg::t_cls    i_cls,
    output logic             o_q_pop,
    output logic             o_clearing,
    output rrt_pkg::t_result o_result,
    output logic             o_empty,
    input  logic             i_pop
);
    import rrt_pkg::*;

    localparam int CH = REGION_WIDTH * REGION_HEIGHT;
    localparam int SB = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int FD = MAX_REGIONS * CH;
    localparam int FA = (FD > 1) ? $clog2(FD) : 1;
    localparam int CB = $clog2(CH + 1);
    localparam int IB = (CH > 1) ? $clog2(CH) : 1;

    t_state                 r_state;
    t_state                 n_state;
    logic [FA-1:0]          r_clr;
    t_cls                   r_cur;
    logic [MAX_REGIONS-1:0] r_hit;
    logic [MAX_REGIONS-1:0] r_free;
    logic [IB-1:0]          r_idx;
    logic [SB-1:0]          r_s;
    logic                   r_found;
    logic                   r_full;
    logic [FA-1:0]          r_addr;
    logic                   r_flag;
    logic [MAX_REGIONS-1:0] r_valid;
    logic [COORD_BITS-1:0]  r_olon [MAX_REGIONS];
    logic [COORD_BITS-1:0]  r_olat [MAX_REGIONS];
    logic [CB-1:0]          r_cnt  [MAX_REGIONS];
    t_result                r_out;
    logic                   r_out_valid;
    logic                   m_flag [FD];

    logic [MAX_REGIONS-1:0] hit;
    logic [SB-1:0]          hit_s;
    logic [SB-1:0]          free_s;
    logic                   found;
    logic                   full;
    logic [SB-1:0]          sel_s;
    logic [FA-1:0]          rd_addr;
    logic                   out_free;
    logic                   commit;
    logic                   flag_eff;
    logic [CB-1:0]          cnt_cur;
    logic [CB-1:0]          cnt_new;
    logic                   set_flag;
    logic                   clr_flag;
    logic                   alloc;
    logic                   free_slot;
    logic                   load;
    logic                   save;
    logic                   mem_we;
    logic [FA-1:0]          mem_waddr;
    logic                   mem_wdata;
    t_result                n_out;

    assign out_free = !r_out_valid || i_pop;
    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

    // Slot match against the current region origin.
    always_comb begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
            hit[i] = r_valid[i] && (r_olon[i] == r_cur.olon) && (r_olat[i] == r_cur.olat);
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb begin
        hit_s  = '0;
        free_s = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                hit_s = SB'(i);
            end
            if (r_free[i]) begin
                free_s = SB'(i);
            end
        end
        found   = |r_hit;
        full    = !found && !(|r_free);
        sel_s   = found ? hit_s : free_s;
        rd_addr = FA'(32'(sel_s) * 32'(CH) + 32'(r_idx));
    end

    // Update of flag, count and slot for the item at hand. A free slot always
    // has a zero count and all its flags clear, so it needs no sweep on allocation.
    always_comb begin
        flag_eff  = r_found && r_flag;
        cnt_cur   = r_found ? r_cnt[r_s] : '0;
        set_flag  = !r_full && !r_cur.release_op && !flag_eff;
        clr_flag  = !r_full && r_cur.release_op && r_found && flag_eff;
        if (set_flag) begin
            cnt_new = cnt_cur + CB'(1);
        end else if (clr_flag && (cnt_cur != '0)) begin
            cnt_new = cnt_cur - CB'(1);
        end else begin
            cnt_new = cnt_cur;
        end
        alloc     = !r_full && !r_found && !r_cur.release_op;
        free_slot = !r_full && r_cur.release_op && r_found && (cnt_new == '0);
        load      = !r_full && !r_found;
        save      = (load && r_cur.release_op) || free_slot;

        n_out.region_lon   = r_cur.olon;
        n_out.region_lat   = r_cur.olat;
        n_out.chunk_index  = 8'(r_idx);
        n_out.slot         = r_full ? 4'd0 : 4'(r_s);
        n_out.load_request = load;
        n_out.save_request = save;
        n_out.flag_changed = set_flag || clr_flag;
        n_out.table_full   = r_full;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == FA'(FD - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH:  n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_q_pop    = 1'b0;
        o_clearing = 1'b0;
        commit     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_clearing = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = r_clr;
            end
            ST_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            ST_MATCH, ST_READ: begin
            end
            ST_UPDATE: begin
                commit    = out_free;
                mem_we    = out_free && (set_flag || clr_flag);
                mem_wdata = set_flag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_REGIONS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + FA'(1);
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (commit && !r_full && (r_found || !r_cur.release_op)) begin
                r_cnt[r_s] <= cnt_new;
            end
            if (commit && alloc) begin
                r_valid[r_s] <= 1'b1;
            end else if (commit && free_slot) begin
                r_valid[r_s] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_cls;
        end
        if (r_state == ST_MATCH) begin
            r_hit  <= hit;
            r_free <= ~r_valid;
            r_idx  <= IB'(32'(r_cur.rx) + 32'(r_cur.ry) * 32'(REGION_WIDTH));
        end
        if (r_state == ST_READ) begin
            r_s     <= sel_s;
            r_found <= found;
            r_full  <= full;
            r_addr  <= rd_addr;
        end
        if (commit && alloc) begin
            r_olon[r_s] <= r_cur.olon;
            r_olat[r_s] <= r_cur.olat;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    // Chunk use flags: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_flag[mem_waddr] <= mem_wdata;
        end
        if (r_state == ST_READ) begin
            r_flag <= m_flag[rd_addr];
        end
    end

endmodule
